FILE: rtl/madt_pkg.sv
// Shared types, constants and helpers for the MADT entry parser.
package madt_pkg;

    localparam int unsigned CPU_LIMIT_DEFAULT = 16;
    localparam int unsigned CNT_W             = 5;
    localparam int unsigned IDX_W             = 4;
    localparam int unsigned ADDR_W            = 32;
    localparam int unsigned OFS_W             = 32;
    localparam int unsigned QUEUE_DEPTH       = 4;
    localparam int unsigned QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OFS_W-1:0] ENTRY_BASE   = 32'd44;

    localparam logic       KIND_CPU           = 1'b0;
    localparam logic       KIND_SUMMARY       = 1'b1;

    localparam logic [1:0] ST_OK              = 2'd0;
    localparam logic [1:0] ST_BAD_SIG         = 2'd1;
    localparam logic [1:0] ST_BAD_SUM         = 2'd2;
    localparam logic [1:0] ST_LEN_MISMATCH    = 2'd3;

    localparam logic [7:0] ENTRY_LAPIC        = 8'd0;
    localparam logic [7:0] ENTRY_IOAPIC       = 8'd1;
    localparam logic [7:0] MIN_ENTRY_LEN      = 8'd2;

    // Command handed from the front end to the output stage
    typedef struct packed {
        logic              has_cpu;
        logic [7:0]        apic_id;
        logic [IDX_W-1:0]  cpu_index;
        logic [CNT_W-1:0]  cpu_count;
        logic              has_sum;
        logic [CNT_W-1:0]  sum_count;
        logic [ADDR_W-1:0] ioapic_address;
        logic [1:0]        status;
    } madt_cmd_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        apic_id;
        logic [IDX_W-1:0]  cpu_index;
        logic [CNT_W-1:0]  cpu_count;
        logic [ADDR_W-1:0] ioapic_address;
        logic [1:0]        status;
        logic              run_end;
    } madt_res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } madt_qstat_t;

    // "APIC" signature, bytes 0..3
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h41;
            2'd1:    r = 8'h50;
            2'd2:    r = 8'h49;
            2'd3:    r = 8'h43;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/madt_if.sv
// Handshake interfaces for the byte input and result output channels.
interface madt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface madt_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  apic_id;
    logic [3:0]  cpu_index;
    logic [4:0]  cpu_count;
    logic [31:0] ioapic_address;
    logic [1:0]  status;
    logic        run_end;

    modport source (output valid, output kind, output apic_id, output cpu_index,
                    output cpu_count, output ioapic_address, output status,
                    output run_end, input ready);
    modport sink   (input valid, input kind, input apic_id, input cpu_index,
                    input cpu_count, input ioapic_address, input status,
                    input run_end, output ready);
endinterface

FILE: rtl/madt_front.sv
// Front end: takes one table byte per cycle while the queue has room, tracks header and entry state.
module madt_front
    import madt_pkg::*;
#(
    parameter int unsigned CPU_LIMIT = CPU_LIMIT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    madt_byte_if.sink   bytes,
    input  madt_qstat_t qstat,
    output logic        push,
    output madt_cmd_t   cmd
);

    localparam int unsigned CPU_CAP   = (CPU_LIMIT < 31) ? CPU_LIMIT : 31;
    localparam logic [CNT_W-1:0] CPU_CAP_W = CNT_W'(CPU_CAP);

    logic [OFS_W-1:0]  offset_reg,  offset_next;
    logic [7:0]        sum_reg,     sum_next;
    logic              sig_ok_reg,  sig_ok_next;
    logic [OFS_W-1:0]  tlen_reg,    tlen_next;
    logic [OFS_W-1:0]  estart_reg,  estart_next;
    logic [7:0]        etype_reg,   etype_next;
    logic [7:0]        elen_reg,    elen_next;
    logic              stop_reg,    stop_next;
    logic [7:0]        apic_reg,    apic_next;
    logic [ADDR_W-1:0] caddr_reg,   caddr_next;
    logic [CNT_W-1:0]  cpus_reg,    cpus_next;
    logic [ADDR_W-1:0] ioapic_reg,  ioapic_next;

    logic              accept;
    logic [7:0]        b;
    logic [OFS_W-1:0]  o;
    logic [OFS_W-1:0]  rel;
    logic              in_entry;
    logic              end_hit;
    logic              cpu_hit;
    logic [OFS_W:0]    next_start;
    logic [OFS_W:0]    count;
    logic [1:0]        status;

    assign bytes.ready = !qstat.full;
    assign accept      = bytes.valid && bytes.ready;
    assign b           = bytes.data_byte;
    assign o           = offset_reg;
    assign rel         = o - estart_reg;

    always_comb
    begin
        offset_next = offset_reg;
        sum_next    = sum_reg + b;
        sig_ok_next = sig_ok_reg;
        tlen_next   = tlen_reg;
        estart_next = estart_reg;
        etype_next  = etype_reg;
        elen_next   = elen_reg;
        stop_next   = stop_reg;
        apic_next   = apic_reg;
        caddr_next  = caddr_reg;
        cpus_next   = cpus_reg;
        ioapic_next = ioapic_reg;
        end_hit     = 1'b0;
        cpu_hit     = 1'b0;
        next_start  = {1'b0, estart_reg} + {{(OFS_W - 7){1'b0}}, elen_next};

        // header: signature then little-endian length
        if (o < 32'd4)
        begin
            if (b != sig_byte(o[1:0]))
                sig_ok_next = 1'b0;
        end
        else if (o < 32'd8)
        begin
            tlen_next[8*o[1:0] +: 8] = tlen_reg[8*o[1:0] +: 8] | b;
        end

        in_entry = (o >= ENTRY_BASE) && sig_ok_reg && !stop_reg &&
                   (o >= estart_reg) && (o < tlen_reg);

        if (in_entry)
        begin
            if (rel == 32'd0)
            begin
                etype_next = b;
                elen_next  = 8'd0;
                apic_next  = 8'd0;
                caddr_next = '0;
            end
            else if (rel == 32'd1)
            begin
                elen_next = b;
                if (b < MIN_ENTRY_LEN)
                    stop_next = 1'b1;
            end
            else if (rel == 32'd3)
            begin
                apic_next = b;
            end
            else if (rel >= 32'd4 && rel <= 32'd7)
            begin
                caddr_next[8*rel[1:0] +: 8] = caddr_reg[8*rel[1:0] +: 8] | b;
            end

            next_start = {1'b0, estart_reg} + {{(OFS_W - 7){1'b0}}, elen_next};
            // elen_next is at least 2 here whenever parsing is still live
            end_hit = !stop_next && (rel != 32'd0) && (rel[OFS_W-1:8] == '0) &&
                      (rel[7:0] == elen_next - 8'd1);

            if (end_hit)
            begin
                if (etype_next == ENTRY_LAPIC)
                begin
                    if (caddr_next[0] && (cpus_reg < CPU_CAP_W))
                    begin
                        cpu_hit   = 1'b1;
                        cpus_next = cpus_reg + 1'b1;
                    end
                end
                else if (etype_next == ENTRY_IOAPIC)
                begin
                    if (ioapic_reg == '0)
                        ioapic_next = caddr_next;
                end
                if (next_start[OFS_W])
                    stop_next = 1'b1;
                else
                    estart_next = next_start[OFS_W-1:0];
            end
        end

        if (o != '1)
            offset_next = o + 1'b1;

        // summary status, in priority order
        count = {1'b0, o} + 1'b1;
        if (!sig_ok_next || (o < 32'd3))
            status = ST_BAD_SIG;
        else if (count != {1'b0, tlen_next})
            status = ST_LEN_MISMATCH;
        else if (sum_next != 8'd0)
            status = ST_BAD_SUM;
        else
            status = ST_OK;

        cmd.has_cpu        = cpu_hit;
        cmd.apic_id        = apic_next;
        cmd.cpu_index      = cpus_reg[IDX_W-1:0];
        cmd.cpu_count      = cpus_next;
        cmd.has_sum        = bytes.last;
        cmd.sum_count      = cpus_next;
        cmd.ioapic_address = ioapic_next;
        cmd.status         = status;

        if (bytes.last)
        begin
            offset_next = '0;
            sum_next    = 8'd0;
            sig_ok_next = 1'b1;
            tlen_next   = '0;
            estart_next = ENTRY_BASE;
            etype_next  = 8'd0;
            elen_next   = 8'd0;
            stop_next   = 1'b0;
            apic_next   = 8'd0;
            caddr_next  = '0;
            cpus_next   = '0;
            ioapic_next = '0;
        end
    end

    assign push = accept && (cpu_hit || bytes.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            sum_reg    <= 8'd0;
            sig_ok_reg <= 1'b1;
            tlen_reg   <= '0;
            estart_reg <= ENTRY_BASE;
            etype_reg  <= 8'd0;
            elen_reg   <= 8'd0;
            stop_reg   <= 1'b0;
            apic_reg   <= 8'd0;
            caddr_reg  <= '0;
            cpus_reg   <= '0;
            ioapic_reg <= '0;
        end
        else if (accept)
        begin
            offset_reg <= offset_next;
            sum_reg    <= sum_next;
            sig_ok_reg <= sig_ok_next;
            tlen_reg   <= tlen_next;
            estart_reg <= estart_next;
            etype_reg  <= etype_next;
            elen_reg   <= elen_next;
            stop_reg   <= stop_next;
            apic_reg   <= apic_next;
            caddr_reg  <= caddr_next;
            cpus_reg   <= cpus_next;
            ioapic_reg <= ioapic_next;
        end
    end

endmodule

FILE: rtl/madt_queue.sv
// Short command queue between the front end and the output stage.
module madt_queue
    import madt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  madt_cmd_t   push_cmd,
    input  logic        pop,
    output madt_cmd_t   head,
    output madt_qstat_t qstat
);

    madt_cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg,    cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign qstat.full  = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: rtl/madt_back.sv
// Output stage: expands queued commands into one or two result transactions.
module madt_back
    import madt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  madt_qstat_t   qstat,
    input  madt_cmd_t     head,
    output logic          pop,
    madt_result_if.source results
);

    logic      valid_reg, valid_next;
    logic      pend_reg,  pend_next;
    madt_cmd_t hold_reg,  hold_next;
    madt_res_t res_reg,   res_next;
    logic      out_free;

    function automatic madt_res_t make_sum(input madt_cmd_t c);
        madt_res_t r;
        r.kind           = KIND_SUMMARY;
        r.apic_id        = 8'd0;
        r.cpu_index      = '0;
        r.cpu_count      = c.sum_count;
        r.ioapic_address = c.ioapic_address;
        r.status         = c.status;
        r.run_end        = 1'b1;
        return r;
    endfunction

    function automatic madt_res_t make_cpu(input madt_cmd_t c);
        madt_res_t r;
        r.kind           = KIND_CPU;
        r.apic_id        = c.apic_id;
        r.cpu_index      = c.cpu_index;
        r.cpu_count      = c.cpu_count;
        r.ioapic_address = '0;
        r.status         = ST_OK;
        r.run_end        = !c.has_sum;
        return r;
    endfunction

    assign out_free = !valid_reg || results.ready;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        hold_next  = hold_reg;
        res_next   = res_reg;
        pop        = 1'b0;
        if (out_free)
        begin
            if (pend_reg)
            begin
                // summary that shares a byte with a cpu result
                res_next   = make_sum(hold_reg);
                valid_next = 1'b1;
                pend_next  = 1'b0;
            end
            else if (!qstat.empty)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                if (head.has_cpu)
                begin
                    res_next  = make_cpu(head);
                    pend_next = head.has_sum;
                    hold_next = head;
                end
                else
                begin
                    res_next = make_sum(head);
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    assign results.valid          = valid_reg;
    assign results.kind           = res_reg.kind;
    assign results.apic_id        = res_reg.apic_id;
    assign results.cpu_index      = res_reg.cpu_index;
    assign results.cpu_count      = res_reg.cpu_count;
    assign results.ioapic_address = res_reg.ioapic_address;
    assign results.status         = res_reg.status;
    assign results.run_end        = res_reg.run_end;

endmodule

FILE: rtl/madt_entry_parser_core.sv
// Top level of the byte-serial MADT entry parser.
//
//   channel   dir  payload                                    handshake
//   bytes     in   data_byte[7:0], last                       valid/ready
//   results   out  kind, apic_id, cpu_index, cpu_count,       valid/ready
//                  ioapic_address, status, run_end
//
// One byte per cycle while the queue has room; the front end updates all table
// state in the accept cycle. A byte that ends the table, or an enabled local APIC
// entry below the CPU limit, queues one command; a byte doing both yields a cpu
// result, then a summary. Results come from an output register after the queue.
// A four-entry command queue lets input continue while results are stalled.
// Reset clears all table state and returns the parser to offset zero.
module madt_entry_parser_core
    import madt_pkg::*;
#(
    parameter int unsigned CPU_LIMIT = CPU_LIMIT_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    madt_byte_if.sink     bytes,
    madt_result_if.source results
);

    logic        push;
    logic        pop;
    madt_cmd_t   push_cmd;
    madt_cmd_t   head;
    madt_qstat_t qstat;

    madt_front #(
        .CPU_LIMIT (CPU_LIMIT)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .qstat (qstat),
        .push  (push),
        .cmd   (push_cmd)
    );

    madt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    madt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .qstat   (qstat),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

FILE: verif/madt_entry_parser_core_test.sv
// Self-checking testbench for madt_entry_parser_core: random MADT images, predicted results.
module madt_entry_parser_core_test;
    import madt_pkg::*;

    localparam int unsigned TB_CPU_LIMIT   = CPU_LIMIT_DEFAULT;
    localparam int unsigned RANDOM_BYTES   = 1100;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned CSUM_AT        = 9;
    localparam logic [31:0] SIGNATURE      = "APIC";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    logic clk;
    logic rst_n;

    madt_byte_if   byte_bus ();
    madt_result_if result_bus ();

    madt_entry_parser_core #(
        .CPU_LIMIT (TB_CPU_LIMIT)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_bus),
        .results (result_bus)
    );

    stream_byte_t byte_queue [$];
    madt_res_t    expected_results [$];
    logic [7:0]   img [$];

    // Predicted parser state
    logic [31:0] cur_offset;
    logic [7:0]  run_sum;
    logic        sig_good;
    logic [31:0] decl_length;
    logic [31:0] ent_start;
    logic [7:0]  ent_type;
    logic [7:0]  ent_len;
    logic        walk_stopped;
    logic [7:0]  ent_apic_id;
    logic [31:0] ent_dword;
    logic [4:0]  cpus_seen;
    logic [31:0] ioapic_first;

    int unsigned  mismatches;
    int unsigned  n_tables;
    int unsigned  n_bytes_sent;
    int unsigned  cpus_checked;
    int unsigned  summaries_checked;
    int unsigned  status_hits [4];
    int unsigned  gap_left;
    int unsigned  stall_left;
    int unsigned  idle_cycles;
    logic [31:0]  cycle_no;
    stream_byte_t next_byte;
    madt_res_t    seen_result;

    // Stretches with no idling on either side
    wire calm = (cycle_no[9:8] == 2'b11);

    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_parse_state();
        cur_offset   = '0;
        run_sum      = '0;
        sig_good     = 1'b1;
        decl_length  = '0;
        ent_start    = ENTRY_BASE;
        ent_type     = '0;
        ent_len      = '0;
        walk_stopped = 1'b0;
        ent_apic_id  = '0;
        ent_dword    = '0;
        cpus_seen    = '0;
        ioapic_first = '0;
    endtask

    task automatic parse_madt_byte(input logic [7:0] b, input logic is_last);
        madt_res_t   outs [2];
        int          n;
        logic [31:0] o;
        logic [31:0] rel;
        logic [32:0] next_start;
        logic [32:0] rx_count;
        logic [1:0]  st;
        n = 0;
        o = cur_offset;
        run_sum = run_sum + b;

        if (o < 4)
        begin
            if (b != SIGNATURE[8 * (3 - o[1:0]) +: 8])
                sig_good = 1'b0;
        end
        else if (o < 8)
        begin
            decl_length = decl_length | ({24'd0, b} << (8 * (o - 4)));
        end

        if (o >= ENTRY_BASE && sig_good && !walk_stopped && o >= ent_start && o < decl_length)
        begin
            rel = o - ent_start;
            if (rel == 0)
            begin
                ent_type    = b;
                ent_len     = '0;
                ent_apic_id = '0;
                ent_dword   = '0;
            end
            else if (rel == 1)
            begin
                ent_len = b;
                if (b < MIN_ENTRY_LEN)
                    walk_stopped = 1'b1;
            end
            else if (rel == 3)
            begin
                ent_apic_id = b;
            end
            else if (rel >= 4 && rel <= 7)
            begin
                ent_dword = ent_dword | ({24'd0, b} << (8 * (rel - 4)));
            end

            // last byte of the entry
            if (!walk_stopped && rel >= 1 && rel == {24'd0, ent_len} - 32'd1)
            begin
                next_start = {1'b0, ent_start} + {25'd0, ent_len};
                if (ent_type == ENTRY_LAPIC)
                begin
                    if (ent_dword[0] && cpus_seen < TB_CPU_LIMIT && cpus_seen < 31)
                    begin
                        outs[n]           = '0;
                        outs[n].kind      = KIND_CPU;
                        outs[n].apic_id   = ent_apic_id;
                        outs[n].cpu_index = cpus_seen[3:0];
                        outs[n].cpu_count = cpus_seen + 5'd1;
                        n++;
                        cpus_seen = cpus_seen + 5'd1;
                    end
                end
                else if (ent_type == ENTRY_IOAPIC)
                begin
                    if (ioapic_first == 0)
                        ioapic_first = ent_dword;
                end
                if (next_start > 33'hFFFF_FFFF)
                    walk_stopped = 1'b1;
                else
                    ent_start = next_start[31:0];
            end
        end

        if (cur_offset != '1)
            cur_offset = cur_offset + 32'd1;

        if (is_last)
        begin
            rx_count = {1'b0, o} + 33'd1;
            if (!sig_good || rx_count < 4)
                st = ST_BAD_SIG;
            else if (rx_count != {1'b0, decl_length})
                st = ST_LEN_MISMATCH;
            else if (run_sum != 0)
                st = ST_BAD_SUM;
            else
                st = ST_OK;
            outs[n]                = '0;
            outs[n].kind           = KIND_SUMMARY;
            outs[n].cpu_count      = cpus_seen;
            outs[n].ioapic_address = ioapic_first;
            outs[n].status         = st;
            n++;
            clear_parse_state();
        end

        if (n > 0)
            outs[n - 1].run_end = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(outs[i]);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input madt_res_t got);
        madt_res_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with nothing pending: kind %0d status %0d", got.kind, got.status);
            mismatches++;
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("apic_id", 32'(want.apic_id), 32'(got.apic_id));
            compare_field("cpu_index", 32'(want.cpu_index), 32'(got.cpu_index));
            compare_field("cpu_count", 32'(want.cpu_count), 32'(got.cpu_count));
            compare_field("ioapic_address", want.ioapic_address, got.ioapic_address);
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("run_end", 32'(want.run_end), 32'(got.run_end));
            if (got.kind == KIND_SUMMARY)
            begin
                summaries_checked++;
                status_hits[got.status]++;
            end
            else
            begin
                cpus_checked++;
            end
        end
    endtask

    task automatic add_random_bytes(input int unsigned n);
        repeat (n)
            img.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            img.push_back(w[8 * i +: 8]);
    endtask

    task automatic add_signature();
        for (int i = 0; i < 4; i++)
            img.push_back(SIGNATURE[8 * (3 - i) +: 8]);
    endtask

    task automatic put_length(input logic [31:0] len);
        for (int i = 0; i < 4; i++)
            img[4 + i] = len[8 * i +: 8];
    endtask

    task automatic fix_checksum();
        logic [7:0] s;
        s = '0;
        img[CSUM_AT] = '0;
        foreach (img[i])
            s = s + img[i];
        img[CSUM_AT] = 8'd0 - s;
    endtask

    task automatic send_image();
        stream_byte_t sb;
        foreach (img[i])
        begin
            sb.data = img[i];
            sb.last = (i == img.size() - 1);
            byte_queue.push_back(sb);
        end
        n_bytes_sent += img.size();
        n_tables++;
        img.delete();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n              = 1'b0;
        byte_bus.valid     = 1'b0;
        byte_bus.data_byte = '0;
        byte_bus.last      = 1'b0;
        result_bus.ready   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Byte driver; the predictor runs on every accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_bus.valid     <= 1'b0;
            byte_bus.data_byte <= '0;
            byte_bus.last      <= 1'b0;
            gap_left = 0;
            clear_parse_state();
        end
        else
        begin
            if (byte_bus.valid && byte_bus.ready)
                parse_madt_byte(byte_bus.data_byte, byte_bus.last);
            if (!byte_bus.valid || byte_bus.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    byte_bus.valid <= 1'b0;
                end
                else if (byte_queue.size() != 0)
                begin
                    next_byte = byte_queue.pop_front();
                    byte_bus.valid     <= 1'b1;
                    byte_bus.data_byte <= next_byte.data;
                    byte_bus.last      <= next_byte.last;
                    gap_left = draw_gap();
                end
                else
                begin
                    byte_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                seen_result = '{kind: result_bus.kind, apic_id: result_bus.apic_id,
                                cpu_index: result_bus.cpu_index,
                                cpu_count: result_bus.cpu_count,
                                ioapic_address: result_bus.ioapic_address,
                                status: result_bus.status, run_end: result_bus.run_end};
                check_result(seen_result);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                stall_left = draw_gap();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles = 0;
            cycle_no    = '0;
        end
        else
        begin
            cycle_no = cycle_no + 32'd1;
            if ((byte_bus.valid && byte_bus.ready) || (result_bus.valid && result_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no transaction for %0d cycles, %0d results still pending",
                       idle_cycles, expected_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned flavor;
        int unsigned n_ent;
        int unsigned pick;
        int unsigned len;
        int unsigned m;
        logic        heavy;
        logic [31:0] flags;

        mismatches        = 0;
        n_tables          = 0;
        n_bytes_sent      = 0;
        cpus_checked      = 0;
        summaries_checked = 0;
        foreach (status_hits[i])
            status_hits[i] = 0;

        // Directed: one-byte tables at both byte extremes, a table cut inside
        // the signature, a header-only good table and one with a bad sum.
        img.push_back(8'hFF);
        send_image();
        img.push_back(8'h00);
        send_image();
        add_signature();
        void'(img.pop_back());
        send_image();
        add_signature();
        add_word(32'd10);
        add_random_bytes(2);
        fix_checksum();
        send_image();
        add_signature();
        add_word(32'd8);
        send_image();

        while (n_bytes_sent < RANDOM_BYTES)
        begin
            flavor = $urandom_range(0, 99);
            if (flavor < 8)
            begin
                if ($urandom_range(0, 1) == 1)
                    add_signature();
                add_random_bytes($urandom_range(1, 48));
            end
            else
            begin
                add_signature();
                add_word('0);
                add_random_bytes(36);
                heavy = ($urandom_range(0, 5) == 0);
                n_ent = heavy ? $urandom_range(17, 21) : $urandom_range(0, 7);
                repeat (n_ent)
                begin
                    pick = heavy ? 0 : $urandom_range(0, 99);
                    if (pick < 50)
                    begin
                        img.push_back(ENTRY_LAPIC);
                        img.push_back(8'd8);
                        add_random_bytes(2);
                        flags = $urandom;
                        flags[0] = heavy || ($urandom_range(0, 4) != 0);
                        add_word(flags);
                    end
                    else if (pick < 70)
                    begin
                        img.push_back(ENTRY_IOAPIC);
                        img.push_back(8'd12);
                        add_random_bytes(1);
                        img.push_back(8'd0);
                        add_word(($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom));
                        add_word($urandom);
                    end
                    else if (pick < 85)
                    begin
                        len = $urandom_range(2, 20);
                        img.push_back(8'($urandom_range(2, 255)));
                        img.push_back(8'(len));
                        add_random_bytes(len - 2);
                    end
                    else if (pick < 91)
                    begin
                        // typed entry too short to hold all its fields
                        len = $urandom_range(2, 7);
                        img.push_back(($urandom_range(0, 1) == 0) ? ENTRY_LAPIC : ENTRY_IOAPIC);
                        img.push_back(8'(len));
                        add_random_bytes(len - 2);
                    end
                    else if (pick < 94)
                    begin
                        // length below 2 ends the walk
                        add_random_bytes(1);
                        img.push_back(8'($urandom_range(0, 1)));
                    end
                    else
                    begin
                        len = $urandom_range(9, 24);
                        img.push_back(ENTRY_LAPIC);
                        img.push_back(8'(len));
                        add_random_bytes(2);
                        add_word(32'($urandom) | 32'd1);
                        add_random_bytes(len - 8);
                    end
                end
                put_length(32'(img.size()));
                fix_checksum();

                m = $urandom_range(0, 99);
                if (m < 50)
                begin
                end
                else if (m < 58)
                    img[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
                else if (m < 66)
                    img[CSUM_AT] = img[CSUM_AT] + 8'($urandom_range(1, 255));
                else if (m < 73)
                    put_length($urandom_range(8, img.size() - 1));
                else if (m < 79)
                    put_length(32'(img.size()) + 32'($urandom_range(1, 24)));
                else if (m < 83)
                    put_length(($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'($urandom));
                else if (m < 91)
                    repeat ($urandom_range(1, img.size() - 1))
                        void'(img.pop_back());
                else
                    add_random_bytes($urandom_range(1, 16));
            end
            send_image();
        end

        while (byte_queue.size() != 0 || byte_bus.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d bytes in %0d tables; checked %0d cpu results and %0d summaries",
                 n_bytes_sent, n_tables, cpus_checked, summaries_checked);
        $display("Summary status mix: ok %0d, bad signature %0d, bad checksum %0d, length %0d",
                 status_hits[ST_OK], status_hits[ST_BAD_SIG], status_hits[ST_BAD_SUM],
                 status_hits[ST_LEN_MISMATCH]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
